FILE: rtl/luhn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_pkg
// shared widths, codes and controller-to-datapath command type for the luhn
// check and card brand classifier
// ----------------------------------------------------------------------------
package luhn_pkg;

   localparam int BIN_W          = 63;
   localparam int BCD_DIGITS     = 19;
   localparam int BCD_W          = BCD_DIGITS * 4;
   localparam int CNT_W          = 6;
   localparam int COUNT_W        = 5;
   localparam int SUM_W          = 8;
   localparam int SUM_MAX        = 171;
   localparam int DEF_MAX_DIGITS = 19;

   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_INVALID = 2'd0;
   localparam verdict_type VERDICT_AMEX    = 2'd1;
   localparam verdict_type VERDICT_MASTER  = 2'd2;
   localparam verdict_type VERDICT_VISA    = 2'd3;

   localparam logic [COUNT_W-1:0] LEN_AMEX   = 5'd15;
   localparam logic [COUNT_W-1:0] LEN_SHORT  = 5'd13;
   localparam logic [COUNT_W-1:0] LEN_LONG   = 5'd16;

   localparam logic [3:0] DIG_AMEX_HI  = 4'd3;
   localparam logic [3:0] DIG_AMEX_LO0 = 4'd4;
   localparam logic [3:0] DIG_AMEX_LO1 = 4'd7;
   localparam logic [3:0] DIG_MC_HI    = 4'd5;
   localparam logic [3:0] DIG_MC_LO_MIN = 4'd1;
   localparam logic [3:0] DIG_MC_LO_MAX = 4'd5;
   localparam logic [3:0] DIG_VISA     = 4'd4;

   typedef struct packed {
      logic             load;
      logic             conv;
      logic             scan;
      logic             finish;
      logic [CNT_W-1:0] idx;
   } luhn_cmd_type;

endpackage

FILE: rtl/card_number_luhn_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_unit
// luhn mod-10 check and card brand classifier for one binary card number
// ----------------------------------------------------------------------------
// channel   ports                                             handshake
// request   req_card_number                                   start & !busy
// response  rsp_verdict, rsp_checksum_sum, rsp_digit_count    rsp_valid pulse
//
// one transaction runs from accept to the rsp_valid cycle through 63 bcd
// shift steps, a scan at one digit per cycle over MAX_DIGITS digits, and
// the brand decision in the result phase.
// busy is high from the cycle after accept until the result phase ends;
// start can be taken again in the cycle rsp_valid is high.
// synchronous active-high reset returns to idle and clears rsp_valid.
// the receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_unit #(
   parameter int MAX_DIGITS = luhn_pkg::DEF_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [luhn_pkg::BIN_W-1:0]    req_card_number,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_verdict,
   output logic [luhn_pkg::SUM_W-1:0]    rsp_checksum_sum,
   output logic [luhn_pkg::COUNT_W-1:0]  rsp_digit_count
);

   luhn_pkg::luhn_cmd_type cmd;

   luhn_ctrl #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   luhn_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_card_number  (req_card_number),
      .rsp_valid        (rsp_valid),
      .rsp_verdict      (rsp_verdict),
      .rsp_checksum_sum (rsp_checksum_sum),
      .rsp_digit_count  (rsp_digit_count)
   );

endmodule

FILE: rtl/luhn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_ctrl
// sequencer: binary-to-bcd shift phase, digit scan phase, result phase
// ----------------------------------------------------------------------------
module luhn_ctrl #(
   parameter int MAX_DIGITS = luhn_pkg::DEF_MAX_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output luhn_pkg::luhn_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   localparam logic [luhn_pkg::CNT_W-1:0] CONV_LAST =
      luhn_pkg::CNT_W'(luhn_pkg::BIN_W - 1);
   localparam logic [luhn_pkg::CNT_W-1:0] SCAN_LAST =
      luhn_pkg::CNT_W'(MAX_DIGITS - 1);

   state_type                     state_ff, state_in;
   logic [luhn_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (cnt_ff == CONV_LAST) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == SCAN_LAST) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.conv   = (state_ff == ST_CONV);
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.finish = (state_ff == ST_DONE);
   assign cmd.idx    = cnt_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_conv_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV |-> cnt_ff <= CONV_LAST)
      else $error("shift counter out of range");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && cnt_ff == SCAN_LAST |=> state_ff == ST_DONE)
      else $error("scan did not end in result phase");

endmodule

FILE: rtl/luhn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_datapath
// double-dabble bcd conversion, serial digit scan with luhn sum, digit
// count and leading digits, brand decision and result registers
// ----------------------------------------------------------------------------
module luhn_datapath #(
   parameter int MAX_DIGITS = luhn_pkg::DEF_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  luhn_pkg::luhn_cmd_type        cmd,
   input  logic [luhn_pkg::BIN_W-1:0]    req_card_number,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_verdict,
   output logic [luhn_pkg::SUM_W-1:0]    rsp_checksum_sum,
   output logic [luhn_pkg::COUNT_W-1:0]  rsp_digit_count
);

   logic [luhn_pkg::BIN_W-1:0]   bin_ff, bin_in;
   logic [luhn_pkg::BCD_W-1:0]   bcd_ff, bcd_in, bcd_adj;
   logic [luhn_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [3:0]                   mod_ff, mod_in;
   logic [luhn_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [3:0]                   top_hi_ff, top_hi_in;
   logic [3:0]                   top_lo_ff, top_lo_in;
   logic [3:0]                   prev_ff, prev_in;
   logic                         valid_ff;
   luhn_pkg::verdict_type        verdict_ff, verdict_in;
   logic [luhn_pkg::SUM_W-1:0]   rsp_sum_ff;
   logic [luhn_pkg::COUNT_W-1:0] rsp_count_ff;

   logic [3:0] dg;
   logic [4:0] dbl;
   logic [3:0] contrib;
   logic [4:0] mod_sum;

   // add-3 correction on every bcd digit before the shift
   always_comb begin
      for (int k = 0; k < luhn_pkg::BCD_DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] >= 4'd5) begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   // digit contribution, every second digit doubled
   always_comb begin
      dg  = bcd_ff[3:0];
      dbl = {dg, 1'b0};
      if (cmd.idx[0]) begin
         contrib = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
      end else begin
         contrib = dg;
      end
      mod_sum = {1'b0, mod_ff} + {1'b0, contrib};
   end

   always_comb begin
      logic overflow;
      logic amex_hit;
      logic mc_hit;
      logic visa_hit;
      overflow = |bcd_ff;
      amex_hit = (count_ff == luhn_pkg::LEN_AMEX) && (top_hi_ff == luhn_pkg::DIG_AMEX_HI)
                 && ((top_lo_ff == luhn_pkg::DIG_AMEX_LO0)
                     || (top_lo_ff == luhn_pkg::DIG_AMEX_LO1));
      mc_hit   = (count_ff == luhn_pkg::LEN_LONG) && (top_hi_ff == luhn_pkg::DIG_MC_HI)
                 && (top_lo_ff >= luhn_pkg::DIG_MC_LO_MIN)
                 && (top_lo_ff <= luhn_pkg::DIG_MC_LO_MAX);
      visa_hit = ((count_ff == luhn_pkg::LEN_SHORT) || (count_ff == luhn_pkg::LEN_LONG))
                 && (top_hi_ff == luhn_pkg::DIG_VISA);
      priority if (overflow || (mod_ff != 4'd0)) begin
         verdict_in = luhn_pkg::VERDICT_INVALID;
      end else if (amex_hit) begin
         verdict_in = luhn_pkg::VERDICT_AMEX;
      end else if (mc_hit) begin
         verdict_in = luhn_pkg::VERDICT_MASTER;
      end else if (visa_hit) begin
         verdict_in = luhn_pkg::VERDICT_VISA;
      end else begin
         verdict_in = luhn_pkg::VERDICT_INVALID;
      end
   end

   always_comb begin
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      sum_in    = sum_ff;
      mod_in    = mod_ff;
      count_in  = count_ff;
      top_hi_in = top_hi_ff;
      top_lo_in = top_lo_ff;
      prev_in   = prev_ff;
      priority if (cmd.load) begin
         bin_in    = req_card_number;
         bcd_in    = '0;
         sum_in    = '0;
         mod_in    = '0;
         count_in  = '0;
         top_hi_in = '0;
         top_lo_in = '0;
         prev_in   = '0;
      end else if (cmd.conv) begin
         bcd_in = {bcd_adj[luhn_pkg::BCD_W-2:0], bin_ff[luhn_pkg::BIN_W-1]};
         bin_in = {bin_ff[luhn_pkg::BIN_W-2:0], 1'b0};
      end else if (cmd.scan) begin
         bcd_in  = bcd_ff >> 4;
         sum_in  = sum_ff + luhn_pkg::SUM_W'(contrib);
         mod_in  = (mod_sum >= 5'd10) ? 4'(mod_sum - 5'd10) : mod_sum[3:0];
         prev_in = dg;
         // digits remain from here upward
         if (bcd_ff != '0) begin
            count_in  = luhn_pkg::COUNT_W'(cmd.idx + 1'b1);
            top_hi_in = dg;
            top_lo_in = prev_ff;
         end
      end else begin
         bin_in = bin_ff;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      sum_ff    <= sum_in;
      mod_ff    <= mod_in;
      count_ff  <= count_in;
      top_hi_ff <= top_hi_in;
      top_lo_ff <= top_lo_in;
      prev_ff   <= prev_in;
      if (cmd.finish) begin
         verdict_ff   <= verdict_in;
         rsp_sum_ff   <= sum_ff;
         rsp_count_ff <= count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_verdict      = verdict_ff;
   assign rsp_checksum_sum = rsp_sum_ff;
   assign rsp_digit_count  = rsp_count_ff;

   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("result phase without result strobe");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_count <= luhn_pkg::COUNT_W'(MAX_DIGITS))
      else $error("digit count above limit");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_checksum_sum <= luhn_pkg::SUM_W'(luhn_pkg::SUM_MAX))
      else $error("luhn sum above limit");

endmodule
